/* design/twc_pkg.sv */
package twc_pkg;

    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned CNT_W          = 32;
    localparam int unsigned SET_NUM_W      = 10;
    localparam int unsigned LINE_BYTES_DEF = 8;
    localparam int unsigned SET_COUNT_DEF  = 1024;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [SET_NUM_W-1:0] set_num_t;

endpackage

/* design/twc_req_if.sv */
interface twc_req_if import twc_pkg::*; ();

    logic  valid;
    logic  ready;
    addr_t byte_address;

    modport source (output valid, output byte_address, input ready);
    modport sink (input valid, input byte_address, output ready);

endinterface

/* design/twc_rsp_if.sv */
interface twc_rsp_if import twc_pkg::*; ();

    logic     valid;
    logic     ready;
    logic     hit;
    logic     way_used;
    set_num_t set_number;
    count_t   hit_total;
    count_t   miss_total;

    modport source (
        output valid, output hit, output way_used, output set_number,
        output hit_total, output miss_total, input ready
    );
    modport sink (
        input valid, input hit, input way_used, input set_number,
        input hit_total, input miss_total, output ready
    );

endinterface

/* design/two_way_cache_hit_miss_model.sv */
// Hit/miss model of a two-way set-associative cache with one LRU bit per set. Each
// request transfer carries a byte address; each response transfer reports hit or miss,
// the way used, the set index and the saturating hit and miss totals after that access.
// LINE_BYTES and SET_COUNT must be powers of two. All per-set state (both tags, both
// valid bits and the victim bit) lives in one row of a single-port-write, registered-read
// memory of SET_COUNT rows. An access reads its row in the cycle it is accepted and
// writes the updated row back as it leaves stage one; a back-to-back access to the same
// set takes the written row from a bypass register, so the block sustains one access per
// clock while the response side is ready, with the response registered after stage one. After
// reset the block sweeps the memory one row per cycle, holding off requests until it ends.
module two_way_cache_hit_miss_model import twc_pkg::*; #(
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
    parameter int unsigned SET_COUNT  = SET_COUNT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    twc_req_if.sink  req,
    twc_rsp_if.source rsp
);

    localparam int unsigned OFF_W = $clog2(LINE_BYTES);
    localparam int unsigned SET_W = $clog2(SET_COUNT);
    localparam int unsigned TAG_W = ADDR_W - OFF_W - SET_W;

    typedef struct packed {
        logic                  victim;
        logic [1:0]            valid;
        logic [1:0][TAG_W-1:0] tag;
    } row_t;

    row_t mem [SET_COUNT];
    row_t rd_row_reg;
    row_t wb_row_reg;
    row_t cur_row;
    row_t new_row;
    row_t mem_wdata;

    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;

    logic             clr_active_reg;
    logic [SET_W-1:0] clr_idx_reg;

    logic             s1_valid_reg;
    addr_t            s1_addr_reg;
    logic             fwd_reg;
    logic [SET_W-1:0] s1_set;
    logic [TAG_W-1:0] s1_tag;
    logic             s1_fire;

    logic             in_fire;
    logic [SET_W-1:0] in_set;

    logic match0;
    logic match1;
    logic hit_c;
    logic way_c;

    count_t hit_cnt_reg;
    count_t hit_cnt_next;
    count_t miss_cnt_reg;
    count_t miss_cnt_next;

    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic                       out_way_reg;
    set_num_t                   out_set_reg;
    logic [SET_W+SET_NUM_W-1:0] set_wide;

    // Request side
    assign in_set    = req.byte_address[OFF_W +: SET_W];
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign in_fire   = req.valid && req.ready;

    // Lookup and update of the row for the access in stage one
    assign s1_set   = s1_addr_reg[OFF_W +: SET_W];
    assign s1_tag   = s1_addr_reg[ADDR_W-1 -: TAG_W];
    assign cur_row  = fwd_reg ? wb_row_reg : rd_row_reg;
    assign match0   = cur_row.valid[0] && (cur_row.tag[0] == s1_tag);
    assign match1   = cur_row.valid[1] && (cur_row.tag[1] == s1_tag);
    assign hit_c    = match0 || match1;
    assign way_c    = hit_c ? !match0 : cur_row.victim;
    assign set_wide = {{SET_NUM_W{1'b0}}, s1_set};

    always_comb
    begin
        new_row = cur_row;
        if (!hit_c)
        begin
            new_row.tag[way_c]   = s1_tag;
            new_row.valid[way_c] = 1'b1;
        end
        new_row.victim = !way_c;
    end

    assign mem_we    = clr_active_reg || s1_fire;
    assign mem_waddr = clr_active_reg ? clr_idx_reg : s1_set;
    assign mem_wdata = clr_active_reg ? '0 : new_row;

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (s1_fire && hit_c && (hit_cnt_reg != '1))
        begin
            hit_cnt_next = hit_cnt_reg + CNT_W'(1);
        end
        if (s1_fire && !hit_c && (miss_cnt_reg != '1))
        begin
            miss_cnt_next = miss_cnt_reg + CNT_W'(1);
        end
    end

    // Set memory: registered read at accept, write-back from stage one
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_row_reg <= mem[in_set];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= req.byte_address;
        end
        if (s1_fire)
        begin
            wb_row_reg  <= new_row;
            out_hit_reg <= hit_c;
            out_way_reg <= way_c;
            out_set_reg <= set_wide[SET_NUM_W-1:0];
        end
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(SET_COUNT - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                // The row read in this cycle misses the write-back landing at the same edge.
                fwd_reg      <= s1_fire && (s1_set == in_set);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.way_used   = out_way_reg;
    assign rsp.set_number = out_set_reg;
    assign rsp.hit_total  = hit_cnt_reg;
    assign rsp.miss_total = miss_cnt_reg;

    // No request may be taken while the memory sweep is still running.
    assert property (@(posedge clk) disable iff (!rst_n) clr_active_reg |-> !req.ready)
        else $error("request accepted during memory sweep");

    // Both ways of a set never hold the same valid tag; a stale row would break this.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(match0 && match1))
        else $error("both ways hit in one set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && hit_c && (hit_cnt_reg != '1)) |=>
        (hit_cnt_reg == $past(hit_cnt_reg) + CNT_W'(1)))
        else $error("hit count not advanced on hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !hit_c && (miss_cnt_reg != '1)) |=>
        (miss_cnt_reg == $past(miss_cnt_reg) + CNT_W'(1)))
        else $error("miss count not advanced on miss");

endmodule
